>>> src/rfo_pkg.sv
// ----------------------------------------------------------------------------
// rfo_pkg
// Shared types, constants and the step program of the rotor flux observer.
// ----------------------------------------------------------------------------
package rfo_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_TIME_STEP     = 3'd0;
  localparam logic [2:0] CFG_COUPLING_GAIN = 3'd1;
  localparam logic [2:0] CFG_ROTOR_DECAY   = 3'd2;
  localparam logic [2:0] CFG_POLE_PAIRS    = 3'd3;
  localparam logic [2:0] CFG_INIT_ALPHA    = 3'd4;
  localparam logic [2:0] CFG_INIT_BETA     = 3'd5;

  typedef struct packed {
    logic        [16:0] time_step;
    logic signed [31:0] coupling_gain;
    logic signed [31:0] rotor_decay;
    logic        [4:0]  pole_pairs;
    logic signed [31:0] init_alpha;
    logic signed [31:0] init_beta;
  } cfg_t;

  // fixed-point constants in unsigned Q1.16, and one sixth in Q31
  localparam logic [16:0] K0667_Q  = 17'd43713;
  localparam logic [16:0] K0866_Q  = 17'd56754;
  localparam logic [16:0] K06667_Q = 17'd43693;
  localparam logic [28:0] SIXTH_Q  = 29'd357913941;

  // operand A selects
  localparam logic [3:0] A_DIFFA = 4'd0;
  localparam logic [3:0] A_DIFFB = 4'd1;
  localparam logic [3:0] A_TMP   = 4'd2;
  localparam logic [3:0] A_MS    = 4'd3;
  localparam logic [3:0] A_CG    = 4'd4;
  localparam logic [3:0] A_WE    = 4'd5;
  localparam logic [3:0] A_RD    = 4'd6;
  localparam logic [3:0] A_H     = 4'd7;
  localparam logic [3:0] A_KSA   = 4'd8;
  localparam logic [3:0] A_KSB   = 4'd9;
  localparam logic [3:0] A_FA    = 4'd10;
  localparam logic [3:0] A_FB    = 4'd11;

  // operand B selects
  localparam logic [4:0] B_K0667  = 5'd0;
  localparam logic [4:0] B_K0866  = 5'd1;
  localparam logic [4:0] B_K06667 = 5'd2;
  localparam logic [4:0] B_PP     = 5'd3;
  localparam logic [4:0] B_IAL    = 5'd4;
  localparam logic [4:0] B_IBE    = 5'd5;
  localparam logic [4:0] B_PA     = 5'd6;
  localparam logic [4:0] B_PB     = 5'd7;
  localparam logic [4:0] B_K1A    = 5'd8;
  localparam logic [4:0] B_K1B    = 5'd9;
  localparam logic [4:0] B_K2A    = 5'd10;
  localparam logic [4:0] B_K2B    = 5'd11;
  localparam logic [4:0] B_K3A    = 5'd12;
  localparam logic [4:0] B_K3B    = 5'd13;
  localparam logic [4:0] B_SIXTH  = 5'd14;
  localparam logic [4:0] B_HS     = 5'd15;
  localparam logic [4:0] B_FA     = 5'd16;
  localparam logic [4:0] B_FB     = 5'd17;

  // product shift
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_16 = 2'd1;
  localparam logic [1:0] SH_17 = 2'd2;
  localparam logic [1:0] SH_47 = 2'd3;

  // addend selects
  localparam logic [2:0] BS_ZERO = 3'd0;
  localparam logic [2:0] BS_SUM  = 3'd1;
  localparam logic [2:0] BS_CGIA = 3'd2;
  localparam logic [2:0] BS_CGIB = 3'd3;
  localparam logic [2:0] BS_FA   = 3'd4;
  localparam logic [2:0] BS_FB   = 3'd5;

  // destinations
  localparam logic [4:0] D_SUM  = 5'd0;
  localparam logic [4:0] D_TMP  = 5'd1;
  localparam logic [4:0] D_IAL  = 5'd2;
  localparam logic [4:0] D_IBE  = 5'd3;
  localparam logic [4:0] D_WE   = 5'd4;
  localparam logic [4:0] D_CGIA = 5'd5;
  localparam logic [4:0] D_CGIB = 5'd6;
  localparam logic [4:0] D_K1A  = 5'd7;
  localparam logic [4:0] D_K1B  = 5'd8;
  localparam logic [4:0] D_K2A  = 5'd9;
  localparam logic [4:0] D_K2B  = 5'd10;
  localparam logic [4:0] D_K3A  = 5'd11;
  localparam logic [4:0] D_K3B  = 5'd12;
  localparam logic [4:0] D_K4A  = 5'd13;
  localparam logic [4:0] D_K4B  = 5'd14;
  localparam logic [4:0] D_PA   = 5'd15;
  localparam logic [4:0] D_PB   = 5'd16;
  localparam logic [4:0] D_FA   = 5'd17;
  localparam logic [4:0] D_FB   = 5'd18;
  localparam logic [4:0] D_HS   = 5'd19;
  localparam logic [4:0] D_SQ0  = 5'd20;
  localparam logic [4:0] D_SQ1  = 5'd21;

  typedef struct packed {
    logic [3:0] a_sel;
    logic [4:0] b_sel;
    logic [1:0] sh;
    logic [2:0] base;
    logic       sub;
    logic [4:0] dest;
  } op_t;

  localparam logic [5:0] LAST_OP   = 6'd32;
  localparam logic [4:0] ITER_LAST = 5'd31;

  typedef struct packed {
    logic       load_in;
    logic       op_load;
    logic       mul_lo;
    logic       mul_hi;
    logic       wb;
    logic       iter_start;
    logic       iter_step;
    logic       out_load;
    logic [5:0] pc;
  } cmd_t;

  // one observer step: clarke, speed, four derivative stages, update, squares
  function automatic op_t rfo_prog(input logic [5:0] pc);
    op_t op;
    unique case (pc)
      6'd0:  op = '{A_DIFFA, B_K0667,  SH_17, BS_ZERO, 1'b0, D_IAL};
      6'd1:  op = '{A_DIFFB, B_K0866,  SH_16, BS_ZERO, 1'b0, D_TMP};
      6'd2:  op = '{A_TMP,   B_K06667, SH_16, BS_ZERO, 1'b0, D_IBE};
      6'd3:  op = '{A_MS,    B_PP,     SH_0,  BS_ZERO, 1'b0, D_WE};
      6'd4:  op = '{A_CG,    B_IAL,    SH_16, BS_ZERO, 1'b0, D_CGIA};
      6'd5:  op = '{A_CG,    B_IBE,    SH_16, BS_ZERO, 1'b0, D_CGIB};
      6'd6:  op = '{A_H,     B_SIXTH,  SH_0,  BS_ZERO, 1'b0, D_HS};
      6'd7:  op = '{A_WE,    B_PB,     SH_16, BS_CGIA, 1'b1, D_SUM};
      6'd8:  op = '{A_RD,    B_PA,     SH_16, BS_SUM,  1'b1, D_K1A};
      6'd9:  op = '{A_WE,    B_PA,     SH_16, BS_CGIB, 1'b0, D_SUM};
      6'd10: op = '{A_RD,    B_PB,     SH_16, BS_SUM,  1'b1, D_K1B};
      6'd11: op = '{A_H,     B_K1A,    SH_17, BS_FA,   1'b0, D_PA};
      6'd12: op = '{A_H,     B_K1B,    SH_17, BS_FB,   1'b0, D_PB};
      6'd13: op = '{A_WE,    B_PB,     SH_16, BS_CGIA, 1'b1, D_SUM};
      6'd14: op = '{A_RD,    B_PA,     SH_16, BS_SUM,  1'b1, D_K2A};
      6'd15: op = '{A_WE,    B_PA,     SH_16, BS_CGIB, 1'b0, D_SUM};
      6'd16: op = '{A_RD,    B_PB,     SH_16, BS_SUM,  1'b1, D_K2B};
      6'd17: op = '{A_H,     B_K2A,    SH_17, BS_FA,   1'b0, D_PA};
      6'd18: op = '{A_H,     B_K2B,    SH_17, BS_FB,   1'b0, D_PB};
      6'd19: op = '{A_WE,    B_PB,     SH_16, BS_CGIA, 1'b1, D_SUM};
      6'd20: op = '{A_RD,    B_PA,     SH_16, BS_SUM,  1'b1, D_K3A};
      6'd21: op = '{A_WE,    B_PA,     SH_16, BS_CGIB, 1'b0, D_SUM};
      6'd22: op = '{A_RD,    B_PB,     SH_16, BS_SUM,  1'b1, D_K3B};
      6'd23: op = '{A_H,     B_K3A,    SH_16, BS_FA,   1'b0, D_PA};
      6'd24: op = '{A_H,     B_K3B,    SH_16, BS_FB,   1'b0, D_PB};
      6'd25: op = '{A_WE,    B_PB,     SH_16, BS_CGIA, 1'b1, D_SUM};
      6'd26: op = '{A_RD,    B_PA,     SH_16, BS_SUM,  1'b1, D_K4A};
      6'd27: op = '{A_WE,    B_PA,     SH_16, BS_CGIB, 1'b0, D_SUM};
      6'd28: op = '{A_RD,    B_PB,     SH_16, BS_SUM,  1'b1, D_K4B};
      6'd29: op = '{A_KSA,   B_HS,     SH_47, BS_FA,   1'b0, D_FA};
      6'd30: op = '{A_KSB,   B_HS,     SH_47, BS_FB,   1'b0, D_FB};
      6'd31: op = '{A_FA,    B_FA,     SH_0,  BS_ZERO, 1'b0, D_SQ0};
      6'd32: op = '{A_FB,    B_FB,     SH_0,  BS_ZERO, 1'b0, D_SQ1};
      default: op = '0;
    endcase
    return op;
  endfunction

  // arctangent of 2^-i in Q30
  function automatic logic signed [33:0] rfo_atan(input logic [4:0] i);
    logic signed [33:0] v;
    unique case (i)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021688;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775852;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      5'd24: v = 34'sd64;
      5'd25: v = 34'sd32;
      5'd26: v = 34'sd16;
      5'd27: v = 34'sd8;
      5'd28: v = 34'sd4;
      5'd29: v = 34'sd2;
      5'd30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/rfo_in_if.sv
// ----------------------------------------------------------------------------
// rfo_in_if
// Sample channel: phase currents, mechanical speed and restart flag.
// ----------------------------------------------------------------------------
interface rfo_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] current_a;
  logic signed [31:0] current_b;
  logic signed [31:0] current_c;
  logic signed [31:0] mech_speed;
  logic               restart;

  modport source (output valid, current_a, current_b, current_c, mech_speed, restart,
                  input ready);
  modport sink (input valid, current_a, current_b, current_c, mech_speed, restart,
                output ready);
endinterface

>>> src/rfo_out_if.sv
// ----------------------------------------------------------------------------
// rfo_out_if
// Result channel: rotor flux components, amplitude and angle.
// ----------------------------------------------------------------------------
interface rfo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] flux_alpha_out;
  logic signed [31:0] flux_beta_out;
  logic        [30:0] flux_amplitude;
  logic signed [18:0] flux_angle;

  modport source (output valid, flux_alpha_out, flux_beta_out, flux_amplitude, flux_angle,
                  input ready);
  modport sink (input valid, flux_alpha_out, flux_beta_out, flux_amplitude, flux_angle,
                output ready);
endinterface

>>> src/rfo_cfg_if.sv
// ----------------------------------------------------------------------------
// rfo_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rfo_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/rfo_sqrt.sv
// ----------------------------------------------------------------------------
// rfo_sqrt
// Digit-by-digit integer square root, one root bit per step, saturated.
// ----------------------------------------------------------------------------
module rfo_sqrt import rfo_pkg::*; (
  input  logic        clk,
  input  logic        start,
  input  logic        step,
  input  logic [63:0] radicand,
  output logic [30:0] root_sat
);

  logic [63:0] rad_r;
  logic [32:0] rem_r;
  logic [31:0] root_r;
  logic [34:0] rem_sh;
  logic [34:0] trial;

  assign rem_sh = {rem_r, rad_r[63:62]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (step) begin
      rad_r <= {rad_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= 33'(rem_sh - trial);
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[32:0];
        root_r <= {root_r[30:0], 1'b0};
      end
    end
  end

  assign root_sat = root_r[31] ? 31'h7FFF_FFFF : root_r[30:0];

endmodule

>>> src/rfo_cordic.sv
// ----------------------------------------------------------------------------
// rfo_cordic
// Vectoring CORDIC atan2 with quadrant pre-rotation, one iteration per step.
// ----------------------------------------------------------------------------
module rfo_cordic import rfo_pkg::*; (
  input  logic               clk,
  input  logic               start,
  input  logic               step,
  input  logic signed [31:0] fa,
  input  logic signed [31:0] fb,
  output logic signed [18:0] angle
);

  localparam logic signed [33:0] HALFPI_Z = 34'sd1686629713;
  localparam logic signed [33:0] PI_Z     = 34'sd3373259426;

  logic signed [63:0] x_r, y_r, xs, ys, dx, dy;
  logic signed [33:0] z_r, zc, zr;
  logic        [4:0]  cnt_r;
  logic               zero_r;

  assign xs = {{4{fa[31]}}, fa, 28'b0};
  assign ys = {{4{fb[31]}}, fb, 28'b0};
  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;

  always_ff @(posedge clk) begin
    if (start) begin
      zero_r <= (fa == 32'sd0) && (fb == 32'sd0);
      cnt_r  <= '0;
      if (fa[31]) begin
        if (!fb[31]) begin
          x_r <= ys;
          y_r <= -xs;
          z_r <= HALFPI_Z;
        end else begin
          x_r <= -ys;
          y_r <= xs;
          z_r <= -HALFPI_Z;
        end
      end else begin
        x_r <= xs;
        y_r <= ys;
        z_r <= '0;
      end
    end else if (step && (cnt_r != ITER_LAST)) begin
      if (y_r > 64'sd0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + rfo_atan(cnt_r);
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - rfo_atan(cnt_r);
      end
      cnt_r <= cnt_r + 5'd1;
    end
  end

  always_comb begin
    priority if (z_r > PI_Z) begin
      zc = PI_Z;
    end else if (z_r < -PI_Z) begin
      zc = -PI_Z;
    end else begin
      zc = z_r;
    end
    zr = (zc + 34'sd8192) >>> 14;
  end

  assign angle = zero_r ? 19'sd0 : zr[18:0];

endmodule

>>> src/rfo_ctrl.sv
// ----------------------------------------------------------------------------
// rfo_ctrl
// Sequencer: steps the datapath through the program, the root/angle
// iterations and the output handshake.
// ----------------------------------------------------------------------------
module rfo_ctrl import rfo_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LD     = 3'd1;
  localparam logic [2:0] S_MLO    = 3'd2;
  localparam logic [2:0] S_MHI    = 3'd3;
  localparam logic [2:0] S_WB     = 3'd4;
  localparam logic [2:0] S_ISTART = 3'd5;
  localparam logic [2:0] S_ITER   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [5:0] pc_r, pc_nxt;
  logic [4:0] it_r, it_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    it_nxt        = it_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.pc        = pc_r;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          pc_nxt      = '0;
          state_nxt   = S_LD;
        end
      end
      S_LD: begin
        cmd.op_load = 1'b1;
        state_nxt   = S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_WB;
      end
      S_WB: begin
        cmd.wb = 1'b1;
        if (pc_r == LAST_OP) begin
          state_nxt = S_ISTART;
        end else begin
          pc_nxt    = pc_r + 6'd1;
          state_nxt = S_LD;
        end
      end
      S_ISTART: begin
        cmd.iter_start = 1'b1;
        it_nxt         = '0;
        state_nxt      = S_ITER;
      end
      S_ITER: begin
        cmd.iter_step = 1'b1;
        it_nxt        = it_r + 5'd1;
        if (it_r == ITER_LAST) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      it_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      it_r        <= it_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/rfo_datapath.sv
// ----------------------------------------------------------------------------
// rfo_datapath
// Operand registers, shared two-pass multiplier with rounding and
// saturation, flux state, and the root and angle units.
// ----------------------------------------------------------------------------
module rfo_datapath import rfo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  cfg_t               cfg,
  input  logic signed [31:0] current_a,
  input  logic signed [31:0] current_b,
  input  logic signed [31:0] current_c,
  input  logic signed [31:0] mech_speed,
  input  logic               restart,
  output logic signed [31:0] flux_alpha_out,
  output logic signed [31:0] flux_beta_out,
  output logic        [30:0] flux_amplitude,
  output logic signed [18:0] flux_angle
);

  function automatic logic signed [35:0] sx36(input logic signed [31:0] v);
    return {{4{v[31]}}, v};
  endfunction

  function automatic logic signed [46:0] sx47(input logic signed [31:0] v);
    return {{15{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    priority if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic signed [31:0] ia_r, ib_r, ic_r, ms_r;
  logic signed [31:0] fa_r, fb_r, pa_r, pb_r;
  logic signed [31:0] tmp_r, ial_r, ibe_r, we_r, cgia_r, cgib_r;
  logic signed [31:0] k_r [0:7];
  logic signed [35:0] sum_r;
  logic        [45:0] hs_r;
  logic        [63:0] sq_r;
  logic        [34:0] mag_a_r;
  logic        [45:0] mag_b_r;
  logic               neg_r;
  op_t                op_r;
  logic        [80:0] acc_r;

  op_t                op_cur;
  logic signed [35:0] a_val, a_neg;
  logic signed [46:0] b_val, b_neg;
  logic        [22:0] mul_b;
  logic        [57:0] pp;
  logic        [81:0] rnd, t, r_full;
  logic        [31:0] lim, mag32;
  logic signed [35:0] prod, base, res;
  logic signed [31:0] res_sat;
  logic signed [31:0] fa_ld, fb_ld;
  logic        [30:0] amp;
  logic signed [18:0] ang;

  assign op_cur = rfo_prog(cmd.pc);

  // operand select
  always_comb begin
    unique case (op_cur.a_sel)
      A_DIFFA: a_val = (sx36(ia_r) <<< 1) - sx36(ib_r) - sx36(ic_r);
      A_DIFFB: a_val = sx36(ib_r) - sx36(ic_r);
      A_TMP:   a_val = sx36(tmp_r);
      A_MS:    a_val = sx36(ms_r);
      A_CG:    a_val = sx36(cfg.coupling_gain);
      A_WE:    a_val = sx36(we_r);
      A_RD:    a_val = sx36(cfg.rotor_decay);
      A_H:     a_val = {19'b0, cfg.time_step};
      A_KSA:   a_val = sx36(k_r[0]) + (sx36(k_r[2]) <<< 1) + (sx36(k_r[4]) <<< 1)
                       + sx36(k_r[6]);
      A_KSB:   a_val = sx36(k_r[1]) + (sx36(k_r[3]) <<< 1) + (sx36(k_r[5]) <<< 1)
                       + sx36(k_r[7]);
      A_FA:    a_val = sx36(fa_r);
      A_FB:    a_val = sx36(fb_r);
      default: a_val = '0;
    endcase
    unique case (op_cur.b_sel)
      B_K0667:  b_val = {30'b0, K0667_Q};
      B_K0866:  b_val = {30'b0, K0866_Q};
      B_K06667: b_val = {30'b0, K06667_Q};
      B_PP:     b_val = {42'b0, cfg.pole_pairs};
      B_IAL:    b_val = sx47(ial_r);
      B_IBE:    b_val = sx47(ibe_r);
      B_PA:     b_val = sx47(pa_r);
      B_PB:     b_val = sx47(pb_r);
      B_K1A:    b_val = sx47(k_r[0]);
      B_K1B:    b_val = sx47(k_r[1]);
      B_K2A:    b_val = sx47(k_r[2]);
      B_K2B:    b_val = sx47(k_r[3]);
      B_K3A:    b_val = sx47(k_r[4]);
      B_K3B:    b_val = sx47(k_r[5]);
      B_SIXTH:  b_val = {18'b0, SIXTH_Q};
      B_HS:     b_val = {1'b0, hs_r};
      B_FA:     b_val = sx47(fa_r);
      B_FB:     b_val = sx47(fb_r);
      default:  b_val = '0;
    endcase
    a_neg = -a_val;
    b_neg = -b_val;
  end

  // one 35x23 multiplier, low then high half of operand b
  assign mul_b = cmd.mul_hi ? mag_b_r[45:23] : mag_b_r[22:0];
  assign pp    = mag_a_r * mul_b;

  // round half up on the magnitude, saturate, restore sign, add to base
  always_comb begin
    unique case (op_r.sh)
      SH_0:    rnd = '0;
      SH_16:   rnd = 82'd1 << 15;
      SH_17:   rnd = 82'd1 << 16;
      SH_47:   rnd = 82'd1 << 46;
      default: rnd = '0;
    endcase
    t = {1'b0, acc_r} + rnd;
    unique case (op_r.sh)
      SH_0:    r_full = t;
      SH_16:   r_full = t >> 16;
      SH_17:   r_full = t >> 17;
      SH_47:   r_full = t >> 47;
      default: r_full = t;
    endcase
    lim   = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag32 = ((|r_full[81:32]) || (r_full[31:0] > lim)) ? lim : r_full[31:0];
    prod  = neg_r ? -$signed({4'b0, mag32}) : $signed({4'b0, mag32});
    unique case (op_r.base)
      BS_ZERO: base = '0;
      BS_SUM:  base = sum_r;
      BS_CGIA: base = sx36(cgia_r);
      BS_CGIB: base = sx36(cgib_r);
      BS_FA:   base = sx36(fa_r);
      BS_FB:   base = sx36(fb_r);
      default: base = '0;
    endcase
    res     = op_r.sub ? (base - prod) : (base + prod);
    res_sat = sat32(res);
  end

  // restart reloads the state before the step
  assign fa_ld = restart ? cfg.init_alpha : fa_r;
  assign fb_ld = restart ? cfg.init_beta  : fb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_r <= '0;
      fb_r <= '0;
    end else if (cmd.load_in) begin
      fa_r <= fa_ld;
      fb_r <= fb_ld;
    end else if (cmd.wb && (op_r.dest == D_FA)) begin
      fa_r <= res_sat;
    end else if (cmd.wb && (op_r.dest == D_FB)) begin
      fb_r <= res_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ia_r <= current_a;
      ib_r <= current_b;
      ic_r <= current_c;
      ms_r <= mech_speed;
      pa_r <= fa_ld;
      pb_r <= fb_ld;
    end
    if (cmd.op_load) begin
      op_r    <= op_cur;
      mag_a_r <= a_val[35] ? a_neg[34:0] : a_val[34:0];
      mag_b_r <= b_val[46] ? b_neg[45:0] : b_val[45:0];
      neg_r   <= a_val[35] ^ b_val[46];
    end
    if (cmd.mul_lo) begin
      acc_r <= {23'b0, pp};
    end
    if (cmd.mul_hi) begin
      acc_r <= acc_r + {pp, 23'b0};
    end
    if (cmd.wb) begin
      unique case (op_r.dest)
        D_SUM:  sum_r  <= res;
        D_TMP:  tmp_r  <= res_sat;
        D_IAL:  ial_r  <= res_sat;
        D_IBE:  ibe_r  <= res_sat;
        D_WE:   we_r   <= res_sat;
        D_CGIA: cgia_r <= res_sat;
        D_CGIB: cgib_r <= res_sat;
        D_K1A:  k_r[0] <= res_sat;
        D_K1B:  k_r[1] <= res_sat;
        D_K2A:  k_r[2] <= res_sat;
        D_K2B:  k_r[3] <= res_sat;
        D_K3A:  k_r[4] <= res_sat;
        D_K3B:  k_r[5] <= res_sat;
        D_K4A:  k_r[6] <= res_sat;
        D_K4B:  k_r[7] <= res_sat;
        D_PA:   pa_r   <= res_sat;
        D_PB:   pb_r   <= res_sat;
        D_HS:   hs_r   <= acc_r[45:0];
        D_SQ0:  sq_r   <= acc_r[63:0];
        D_SQ1:  sq_r   <= sq_r + acc_r[63:0];
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      flux_alpha_out <= fa_r;
      flux_beta_out  <= fb_r;
      flux_amplitude <= amp;
      flux_angle     <= ang;
    end
  end

  rfo_sqrt u_sqrt (
    .clk      (clk),
    .start    (cmd.iter_start),
    .step     (cmd.iter_step),
    .radicand (sq_r),
    .root_sat (amp)
  );

  rfo_cordic u_cordic (
    .clk   (clk),
    .start (cmd.iter_start),
    .step  (cmd.iter_step),
    .fa    (fa_r),
    .fb    (fb_r),
    .angle (ang)
  );

endmodule

>>> src/rotor_flux_observer_rk4_unit.sv
// ----------------------------------------------------------------------------
// rotor_flux_observer_rk4_unit
// Current-model rotor flux observer, one RK4 step per current sample.
// ----------------------------------------------------------------------------
// in_chan carries three phase currents, mechanical speed and a restart flag;
// out_chan returns the new flux alpha/beta, amplitude and angle, one result
// per sample. cfg_chan writes the six registers (index 0..5), always ready;
// write only while no sample is in flight.
// A sample is taken only while the unit is idle. The step program runs 33
// multiply operations on one shared two-pass multiplier, each as operand
// load, low pass, high pass and write-back, then the square root and
// CORDIC iterations in parallel. The next sample is taken only once the
// result has moved into the output register.
// If the receiver stalls, the finished result holds in the output register
// and the next sample is still accepted and worked on; it waits at the end
// until the previous result is taken.
// Reset clears the flux state to zero and loads the register defaults.
// ----------------------------------------------------------------------------
module rotor_flux_observer_rk4_unit import rfo_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rfo_in_if.sink    in_chan,
  rfo_out_if.source out_chan,
  rfo_cfg_if.sink   cfg_chan
);

  cfg_t cfg_r;
  cmd_t cmd;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.time_step     <= 17'd7;
      cfg_r.coupling_gain <= '0;
      cfg_r.rotor_decay   <= '0;
      cfg_r.pole_pairs    <= 5'd2;
      cfg_r.init_alpha    <= '0;
      cfg_r.init_beta     <= '0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_TIME_STEP:     cfg_r.time_step     <= cfg_chan.data[16:0];
        CFG_COUPLING_GAIN: cfg_r.coupling_gain <= cfg_chan.data;
        CFG_ROTOR_DECAY:   cfg_r.rotor_decay   <= cfg_chan.data;
        CFG_POLE_PAIRS:    cfg_r.pole_pairs    <= cfg_chan.data[4:0];
        CFG_INIT_ALPHA:    cfg_r.init_alpha    <= cfg_chan.data;
        CFG_INIT_BETA:     cfg_r.init_beta     <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  rfo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .cmd       (cmd)
  );

  rfo_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg            (cfg_r),
    .current_a      (in_chan.current_a),
    .current_b      (in_chan.current_b),
    .current_c      (in_chan.current_c),
    .mech_speed     (in_chan.mech_speed),
    .restart        (in_chan.restart),
    .flux_alpha_out (out_chan.flux_alpha_out),
    .flux_beta_out  (out_chan.flux_beta_out),
    .flux_amplitude (out_chan.flux_amplitude),
    .flux_angle     (out_chan.flux_angle)
  );

endmodule

>>> sim/rotor_flux_observer_rk4_unit_tb.sv
// ----------------------------------------------------------------------------
// rotor_flux_observer_rk4_unit_tb
// Self-checking bench for the RK4 rotor flux observer. A queue-fed driver
// sends current samples while a bit-exact flux predictor in the bench works
// out each result. A monitor compares every returned flux, amplitude and angle
// against the oldest prediction. Register settings change between phases,
// with random idling on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module rotor_flux_observer_rk4_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfo_pkg::*;

  typedef struct {
    logic signed [31:0] ia;
    logic signed [31:0] ib;
    logic signed [31:0] ic;
    logic signed [31:0] ms;
    logic               rs;
  } sample_t;

  typedef struct {
    logic signed [31:0] alpha;
    logic signed [31:0] beta;
    logic        [30:0] amp;
    logic signed [18:0] ang;
  } flux_res_t;

  localparam longint DW_MAX   = 64'sd2147483647;
  localparam longint DW_MIN   = -64'sd2147483648;
  localparam longint C0667    = 64'sd1432371593;
  localparam longint C06667   = 64'sd1431727348;
  localparam longint C0866    = 64'sd1859720839;
  localparam longint SIXTH    = 64'sd357913941;
  localparam longint PI_Q30   = 64'sd3373259426;
  localparam longint HPI_Q30  = 64'sd1686629713;
  localparam longint ATAN_Q30 [31] = '{
    843314857, 497837829, 263043837, 133525159, 67021688, 33543516,
    16775852, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1};

  logic clk;
  logic rst_n;

  rfo_in_if  in_bus ();
  rfo_out_if out_bus ();
  rfo_cfg_if cfg_bus ();

  rotor_flux_observer_rk4_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus.sink),
    .out_chan (out_bus.source),
    .cfg_chan (cfg_bus.sink)
  );

  // register copies and flux state of the predictor
  longint cfg_h = 7, cfg_cg = 0, cfg_rd = 0, cfg_pp = 2, cfg_a0 = 0, cfg_b0 = 0;
  longint st_fa = 0, st_fb = 0;

  sample_t   sample_q [$];
  flux_res_t flux_q [$];
  sample_t   offered;
  bit        in_taken, out_taken, hold_req;
  int        in_gap, out_wait, hold_cnt, err_cnt;
  int        in_gap_max = 11, out_gap_max = 11;

  function automatic longint sat_dw(longint v);
    return v < DW_MIN ? DW_MIN : (v > DW_MAX ? DW_MAX : v);
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // exact product, rounded half away from zero, saturated
  function automatic longint mul_rnd(longint a, longint b, int sh);
    logic [127:0] p, r;
    logic         neg;
    longint       lim;
    neg = (a < 0) != (b < 0);
    p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    r = (p + (128'd1 << (sh - 1))) >> sh;
    lim = neg ? 64'sd2147483648 : DW_MAX;
    if (r > 128'(lim)) r = 128'(lim);
    return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  function automatic void flux_slope(input longint pa, pb, ial, ibe, we,
                                     output longint da, db);
    da = sat_dw(mul_rnd(cfg_cg, ial, 16) - mul_rnd(we, pb, 16) - mul_rnd(cfg_rd, pa, 16));
    db = sat_dw(mul_rnd(cfg_cg, ibe, 16) + mul_rnd(we, pa, 16) - mul_rnd(cfg_rd, pb, 16));
  endfunction

  function automatic logic [30:0] flux_magnitude(longint a, longint b);
    logic [127:0] n, c2;
    logic [63:0]  root, cand;
    n = 128'(a < 0 ? -a : a) * 128'(a < 0 ? -a : a)
      + 128'(b < 0 ? -b : b) * 128'(b < 0 ? -b : b);
    root = '0;
    for (int bit_i = 63; bit_i >= 0; bit_i--) begin
      cand = root | (64'd1 << bit_i);
      c2 = 128'(cand) * 128'(cand);
      if (c2 <= n) root = cand;
    end
    return root > 64'h7FFFFFFF ? 31'h7FFFFFFF : root[30:0];
  endfunction

  function automatic logic [18:0] flux_phase(longint a, longint b);
    longint x, y, z, t, dx, dy;
    if (a == 0 && b == 0) return '0;
    x = a <<< 28;
    y = b <<< 28;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HPI_Q30;
      end else begin
        x = -y; y = t; z = -HPI_Q30;
      end
    end
    for (int i = 0; i < 31; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_Q30[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_Q30[i];
      end
    end
    z = z < -PI_Q30 ? -PI_Q30 : (z > PI_Q30 ? PI_Q30 : z);
    z = rnd_shift(z, 14);
    z = z < -262144 ? -262144 : (z > 262143 ? 262143 : z);
    return z[18:0];
  endfunction

  // one observer step: clarke, electrical speed, rk4, then amplitude and angle
  function automatic flux_res_t flux_step(sample_t s);
    longint    ia, ib, ic, ms, fa, fb, ial, ibe, we, h;
    longint    k1a, k1b, k2a, k2b, k3a, k3b, k4a, k4b;
    flux_res_t r;
    ia = longint'(s.ia);
    ib = longint'(s.ib);
    ic = longint'(s.ic);
    ms = longint'(s.ms);
    h = cfg_h;
    if (s.rs) begin
      st_fa = sat_dw(cfg_a0);
      st_fb = sat_dw(cfg_b0);
    end
    fa = st_fa;
    fb = st_fb;
    ial = mul_rnd(2 * ia - ib - ic, rnd_shift(C0667, 15), 17);
    ibe = mul_rnd(mul_rnd(ib - ic, rnd_shift(C0866, 15), 16), rnd_shift(C06667, 15), 16);
    we = sat_dw(ms * cfg_pp);
    flux_slope(fa, fb, ial, ibe, we, k1a, k1b);
    flux_slope(sat_dw(fa + mul_rnd(h, k1a, 17)), sat_dw(fb + mul_rnd(h, k1b, 17)),
               ial, ibe, we, k2a, k2b);
    flux_slope(sat_dw(fa + mul_rnd(h, k2a, 17)), sat_dw(fb + mul_rnd(h, k2b, 17)),
               ial, ibe, we, k3a, k3b);
    flux_slope(sat_dw(fa + mul_rnd(h, k3a, 16)), sat_dw(fb + mul_rnd(h, k3b, 16)),
               ial, ibe, we, k4a, k4b);
    st_fa = sat_dw(fa + mul_rnd(k1a + 2 * k2a + 2 * k3a + k4a, h * SIXTH, 47));
    st_fb = sat_dw(fb + mul_rnd(k1b + 2 * k2b + 2 * k3b + k4b, h * SIXTH, 47));
    r.alpha = st_fa[31:0];
    r.beta  = st_fb[31:0];
    r.amp   = flux_magnitude(st_fa, st_fb);
    r.ang   = flux_phase(st_fa, st_fb);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sample driver
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) begin
      flux_q.push_back(flux_step(offered));
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!(in_bus.valid && !in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_bus.valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        offered = sample_q.pop_front();
        in_bus.current_a  <= offered.ia;
        in_bus.current_b  <= offered.ib;
        in_bus.current_c  <= offered.ic;
        in_bus.mech_speed <= offered.ms;
        in_bus.restart    <= offered.rs;
        in_bus.valid      <= 1'b1;
        in_gap = $urandom_range(0, in_gap_max);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    flux_res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      out_taken = 1'b1;
      if (flux_q.size() == 0) begin
        $display("%0t: result transaction with no prediction pending", $realtime);
        err_cnt++;
      end else begin
        want = flux_q.pop_front();
        if (out_bus.flux_alpha_out !== want.alpha)
          report_mismatch("flux_alpha_out", out_bus.flux_alpha_out, want.alpha);
        if (out_bus.flux_beta_out !== want.beta)
          report_mismatch("flux_beta_out", out_bus.flux_beta_out, want.beta);
        if (out_bus.flux_amplitude !== want.amp)
          report_mismatch("flux_amplitude", out_bus.flux_amplitude, want.amp);
        if (out_bus.flux_angle !== want.ang)
          report_mismatch("flux_angle", out_bus.flux_angle, want.ang);
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_taken) begin
        out_taken = 1'b0;
        out_wait = $urandom_range(0, out_gap_max);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 600;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_bus.ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_bus.valid || flux_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    cfg_bus.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      CFG_TIME_STEP:     cfg_h  = longint'(val[16:0]);
      CFG_COUPLING_GAIN: cfg_cg = longint'(signed'(val));
      CFG_ROTOR_DECAY:   cfg_rd = longint'(signed'(val));
      CFG_POLE_PAIRS:    cfg_pp = longint'(val[4:0]);
      CFG_INIT_ALPHA:    cfg_a0 = longint'(signed'(val));
      CFG_INIT_BETA:     cfg_b0 = longint'(signed'(val));
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] h, cg, rd, pp, a0, b0);
    wait_idle();
    write_reg(CFG_TIME_STEP, h);
    write_reg(CFG_COUPLING_GAIN, cg);
    write_reg(CFG_ROTOR_DECAY, rd);
    write_reg(CFG_POLE_PAIRS, pp);
    write_reg(CFG_INIT_ALPHA, a0);
    write_reg(CFG_INIT_BETA, b0);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic push_sample(input logic [31:0] ia, ib, ic, ms, input logic rs);
    sample_t s;
    s.ia = ia; s.ib = ib; s.ic = ic; s.ms = ms; s.rs = rs;
    sample_q.push_back(s);
  endtask

  function automatic logic [31:0] corner_val();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] rand_signed(int mag);
    return 32'($signed($urandom_range(0, 2 * mag)) - mag);
  endfunction

  task automatic push_random();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 7)
      push_sample(rand_signed(1 << 20), rand_signed(1 << 20), rand_signed(1 << 20),
                  rand_signed(1 << 21), $urandom_range(0, 31) == 0);
    else if (kind < 9)
      push_sample($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
    else
      push_sample(corner_val(), corner_val(), corner_val(), corner_val(),
                  $urandom_range(0, 1));
  endtask

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.current_a = '0;
    in_bus.current_b = '0;
    in_bus.current_c = '0;
    in_bus.mech_speed = '0;
    in_bus.restart = 1'b0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_TIME_STEP;
    cfg_bus.data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // frozen flux: zero vector, then negative real axis gives +pi
    push_sample(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    set_config(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_0000, 32'd0);
    push_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    push_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    push_sample(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd0, 1'b0);
    // largest in-range step, extreme gains
    set_config(32'd65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd16, 32'h7FFF_FFFF,
               32'h8000_0000);
    push_sample(32'd65536, 32'd0, 32'd0, 32'd0, 1'b1);
    push_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    push_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    push_sample(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 1'b0);
    // out-of-range step and pole pairs
    set_config(32'h0001_FFFF, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'h8000_0000,
               32'h7FFF_FFFF);
    push_sample(32'd12345, 32'hFFFF_0000, 32'd99, 32'h7FFF_FFFF, 1'b1);
    push_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    set_config(32'd7, 32'd65536, 32'd32768, 32'd31, 32'd0, 32'd0);
    push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    push_sample(32'd100000, 32'hFFFE_7960, 32'd0, 32'd50000, 1'b0);
    push_sample(32'd100000, 32'hFFFE_7960, 32'd0, 32'hFFFF_3CB0, 1'b0);
    set_config(32'd1, 32'd0, 32'd0, 32'd2, 32'd0, 32'd0);
    push_sample(32'd0, 32'd0, 32'd0, 32'd0, 1'b1);

    for (int ph = 0; ph < 10; ph++) begin
      if (ph % 3 == 2)
        set_config($urandom_range(0, 131071), $urandom, $urandom, $urandom_range(0, 31),
                   $urandom, $urandom);
      else
        set_config($urandom_range(1, 700), $urandom_range(0, 1 << 20),
                   $urandom_range(0, 1 << 22), $urandom_range(1, 16),
                   rand_signed(1 << 18), rand_signed(1 << 18));
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 11;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
      for (int n = 0; n < 193; n++) push_random();
      if (ph == 4) begin
        repeat (300) @(posedge clk);
        hold_req = 1'b1;
      end
    end

    wait_idle();
    repeat (200) @(posedge clk);
    if (err_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #30ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
